/* hdl/stunp_pkg.sv */
`default_nettype none

package stunp_pkg;

  // Byte position counter width; the position saturates at its all-ones value.
  localparam int POSITION_WIDTH = 16;
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  // Header byte positions where the captured field changes, and the last header byte.
  localparam logic [POSITION_WIDTH-1:0] POS_COOKIE   = POSITION_WIDTH'(4);
  localparam logic [POSITION_WIDTH-1:0] POS_TXN_HIGH = POSITION_WIDTH'(8);
  localparam logic [POSITION_WIDTH-1:0] POS_TXN_LOW  = POSITION_WIDTH'(12);
  localparam logic [POSITION_WIDTH-1:0] POS_HDR_LAST = POSITION_WIDTH'(19);

  localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;

  // Attribute header gather count and padded value skip count share one counter.
  localparam int SKIP_W = 17;
  localparam logic [SKIP_W-1:0] ATTR_HDR_BYTES = SKIP_W'(4);

  // Result queue; the depth must be a power of two.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ATTR,
    PH_SKIP,
    PH_IGNORE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_ATTR,
    KIND_END
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_COOKIE,
    ST_PAST_END
  } status_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [15:0] message_type;
    logic [15:0] message_length;
    logic [31:0] txn_high;
    logic [63:0] txn_low;
    logic [15:0] attribute_type;
    logic [15:0] attribute_length;
    logic [15:0] value_offset;
    logic        run_last;
  } result_t;

endpackage

`default_nettype wire

/* hdl/stunp_parse.sv */
`default_nettype none

module stunp_parse (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               data_valid,
  output logic                                    data_stall,
  input  wire logic [7:0]                         data_byte,
  input  wire logic                               final_byte,
  input  wire logic [stunp_pkg::RES_CNT_W-1:0]    level,
  output logic [1:0]                              push_count,
  output stunp_pkg::result_t [1:0]                push_res
);
  import stunp_pkg::*;

  logic                      valid_q;
  logic [7:0]                byte_q;
  logic                      fin_q;

  logic [POSITION_WIDTH-1:0] byte_position, byte_position_next;
  phase_t                    phase, phase_next;
  logic [31:0]               type_len, type_len_next;
  logic [31:0]               cookie_word, cookie_word_next;
  logic [31:0]               txn_high, txn_high_next;
  logic [63:0]               txn_low, txn_low_next;
  logic [31:0]               attr_hdr, attr_hdr_next;
  logic [SKIP_W-1:0]         skip_remaining, skip_remaining_next;

  logic [POSITION_WIDTH-1:0] newpos;
  logic [SKIP_W-1:0]         skip_inc;
  logic [SKIP_W-1:0]         skip_dec;
  logic [SKIP_W-1:0]         padded;
  logic                      body_valid;
  result_t                   body_res;
  result_t                   end_res;
  logic [RES_CNT_W+1:0]      level_ahead;
  logic                      accept;

  // The byte in the input register pushes its results this cycle, and a byte accepted now
  // may push two more in the next one, so keep room for both.
  assign level_ahead = (RES_CNT_W + 2)'(level) + (RES_CNT_W + 2)'(push_count);
  assign data_stall  = level_ahead > (RES_CNT_W + 2)'(RES_DEPTH - 2);
  assign accept      = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
    if (accept) begin
      byte_q <= data_byte;
      fin_q  <= final_byte;
    end
  end

  always_comb begin
    newpos              = (byte_position == POS_MAX) ? POS_MAX : byte_position + 1'b1;
    byte_position_next  = byte_position;
    phase_next          = phase;
    type_len_next       = type_len;
    cookie_word_next    = cookie_word;
    txn_high_next       = txn_high;
    txn_low_next        = txn_low;
    attr_hdr_next       = attr_hdr;
    skip_remaining_next = skip_remaining;
    skip_inc            = skip_remaining + 1'b1;
    skip_dec            = (skip_remaining != '0) ? skip_remaining - 1'b1 : skip_remaining;
    padded              = '0;
    body_valid          = 1'b0;
    body_res            = '0;
    end_res             = '0;

    if (valid_q) begin
      unique case (phase)
        PH_HEADER: begin
          if (byte_position < POS_COOKIE) begin
            type_len_next = {type_len[23:0], byte_q};
          end else if (byte_position < POS_TXN_HIGH) begin
            cookie_word_next = {cookie_word[23:0], byte_q};
          end else if (byte_position < POS_TXN_LOW) begin
            txn_high_next = {txn_high[23:0], byte_q};
          end else begin
            txn_low_next = {txn_low[55:0], byte_q};
          end
          if (byte_position == POS_HDR_LAST) begin
            body_valid              = 1'b1;
            body_res.kind           = KIND_HEADER;
            body_res.message_type   = type_len_next[31:16];
            body_res.message_length = type_len_next[15:0];
            if (cookie_word == MAGIC_COOKIE) begin
              body_res.status     = ST_OK;
              body_res.txn_high   = txn_high_next;
              body_res.txn_low    = txn_low_next;
              phase_next          = PH_ATTR;
              skip_remaining_next = '0;
              attr_hdr_next       = '0;
            end else begin
              body_res.status = ST_COOKIE;
              phase_next      = PH_IGNORE;
            end
          end
        end
        PH_ATTR: begin
          attr_hdr_next       = {attr_hdr[23:0], byte_q};
          padded              = ({1'b0, attr_hdr_next[15:0]} + SKIP_W'(3)) & ~SKIP_W'(3);
          skip_remaining_next = skip_inc;
          if (skip_inc >= ATTR_HDR_BYTES) begin
            body_valid                = 1'b1;
            body_res.kind             = KIND_ATTR;
            body_res.status           = ST_OK;
            body_res.attribute_type   = attr_hdr_next[31:16];
            body_res.attribute_length = attr_hdr_next[15:0];
            body_res.value_offset     = 16'(newpos);
            if (padded != '0) begin
              phase_next          = PH_SKIP;
              skip_remaining_next = padded;
            end else begin
              skip_remaining_next = '0;
            end
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = PH_ATTR;
          end
        end
        PH_IGNORE: begin
        end
        default: begin
        end
      endcase

      byte_position_next = newpos;

      if (fin_q) begin
        end_res.kind = KIND_END;
        unique case (phase_next)
          PH_HEADER: end_res.status = ST_SHORT;
          PH_SKIP:   end_res.status = ST_PAST_END;
          PH_IGNORE: end_res.status = ST_COOKIE;
          default:   end_res.status = ST_OK;
        endcase
        // The message is over; start the next one from a clean state.
        byte_position_next  = '0;
        phase_next          = PH_HEADER;
        type_len_next       = '0;
        cookie_word_next    = '0;
        txn_high_next       = '0;
        txn_low_next        = '0;
        attr_hdr_next       = '0;
        skip_remaining_next = '0;
      end
    end

    end_res.run_last  = 1'b1;
    body_res.run_last = !(valid_q && fin_q);
    push_count        = {1'b0, valid_q && body_valid} + {1'b0, valid_q && fin_q};
    push_res[0]       = body_valid ? body_res : end_res;
    push_res[1]       = end_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      phase          <= PH_HEADER;
      type_len       <= '0;
      cookie_word    <= '0;
      txn_high       <= '0;
      txn_low        <= '0;
      attr_hdr       <= '0;
      skip_remaining <= '0;
    end else begin
      byte_position  <= byte_position_next;
      phase          <= phase_next;
      type_len       <= type_len_next;
      cookie_word    <= cookie_word_next;
      txn_high       <= txn_high_next;
      txn_low        <= txn_low_next;
      attr_hdr       <= attr_hdr_next;
      skip_remaining <= skip_remaining_next;
    end
  end

  a_fin_restarts: assert property (@(posedge clk) disable iff (rst)
    valid_q && fin_q |=> byte_position == '0 && phase == PH_HEADER)
    else $error("parser did not restart after the last byte of a message");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_remaining != '0)
    else $error("skip phase entered with nothing to skip");

  a_header_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> byte_position <= POS_HDR_LAST)
    else $error("header phase ran past the header");

endmodule

`default_nettype wire

/* hdl/stunp_res_fifo.sv */
`default_nettype none

module stunp_res_fifo (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [1:0]                         push_count,
  input  wire stunp_pkg::result_t [1:0]           push_res,
  output logic [stunp_pkg::RES_CNT_W-1:0]         level,
  output logic                                    head_valid,
  output stunp_pkg::result_t                      head,
  input  wire logic                               head_stall
);
  import stunp_pkg::*;

  result_t              entries [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic                 pop;

  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign level      = count;
  assign pop        = head_valid && !head_stall;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_res[0];
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push_res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push_count);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop);
      count  <= count + RES_CNT_W'(push_count) - RES_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (RES_CNT_W + 1)'(count) + (RES_CNT_W + 1)'(push_count) <= (RES_CNT_W + 1)'(RES_DEPTH))
    else $error("result queue overflow");

  a_pop_moves_head: assert property (@(posedge clk) disable iff (rst)
    pop |=> rd_ptr == $past(rd_ptr) + 1'b1)
    else $error("read pointer did not advance on a taken result");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue count out of range");

endmodule

`default_nettype wire

/* hdl/stun_message_parser.sv */
// A request accepted at the input is captured in the input register, and the results it
// yields are written into the result queue, which drives the output.
// The parser takes one byte per cycle while the input is not stalled. A byte can yield
// two results, and a four-entry result queue absorbs these so the input stalls only
// when the queue could not hold the results of the next byte. Reset (rst, synchronous,
// active high) returns the parser to a message start and empties the result queue.
`default_nettype none

module stun_message_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        final_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       result_kind,
  output logic [1:0]       status,
  output logic [15:0]      message_type,
  output logic [15:0]      message_length,
  output logic [31:0]      transaction_id_high,
  output logic [63:0]      transaction_id_low,
  output logic [15:0]      attribute_type,
  output logic [15:0]      attribute_length,
  output logic [15:0]      value_offset,
  output logic             run_last
);
  import stunp_pkg::*;

  // Each input request is registered, then the parser works out the next state and
  // up to two results (a header or attribute result, and an end result on the last
  // byte) in one pass. Those results go into a small queue that feeds the output.
  logic [RES_CNT_W-1:0] level;
  logic [1:0]           push_count;
  result_t [1:0]        push_res;
  result_t              head;

  stunp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .level      (level),
    .push_count (push_count),
    .push_res   (push_res)
  );

  // The queue head is held steady while the output is stalled.
  stunp_res_fifo u_res_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_res   (push_res),
    .level      (level),
    .head_valid (result_valid),
    .head       (head),
    .head_stall (result_stall)
  );

  // Fields that do not belong to a given result kind are carried as zero.
  assign result_kind         = head.kind;
  assign status              = head.status;
  assign message_type        = head.message_type;
  assign message_length      = head.message_length;
  assign transaction_id_high = head.txn_high;
  assign transaction_id_low  = head.txn_low;
  assign attribute_type      = head.attribute_type;
  assign attribute_length    = head.attribute_length;
  assign value_offset        = head.value_offset;
  assign run_last            = head.run_last;

endmodule

`default_nettype wire
